@@ src/cds_pkg.sv @@
// Package for the critically damped smoother: widths, constants, register map.
// No dependencies.
`timescale 1ns / 1ps
package cds_pkg;
    localparam int unsigned WideW = 49;
    localparam logic [30:0] StReset = 31'd6554;
    localparam logic [30:0] MsReset = 31'd65536000;
    localparam logic [30:0] StFloor = 31'd7;
    localparam logic [47:0] WideLim = 48'h7FFF_FFFF_FFFF;
    localparam logic [31:0] XCap = 32'h0020_0000;
    localparam logic [0:0] RegSmoothTime = 1'b0;
    localparam logic [0:0] RegMaxSpeed = 1'b1;

    typedef logic signed [WideW-1:0] wide_t;

    function automatic wide_t sat_wide(input logic signed [WideW+1:0] v);
        wide_t r;
        r = v[WideW-1:0];
        if (v > $signed({2'b00, 1'b0, WideLim})) r = $signed({1'b0, WideLim});
        else if (v < -$signed({2'b00, 1'b0, WideLim})) r = -$signed({1'b0, WideLim});
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        r = v[31:0];
        if (v > $signed({17'd0, 32'h7FFF_FFFF})) r = 32'sh7FFF_FFFF;
        else if (v < $signed({17'h1FFFF, 32'h8000_0000})) r = 32'sh8000_0000;
        return r;
    endfunction
endpackage

@@ src/critically_damped_smoother_unit.sv @@
// Top level of the critically damped smoother: APB registers, sequencer, one
// shared multiplier and the divider. Depends on cds_pkg and cds_div.
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)          | tuser
// s_      | in  | target[31:0], time_step[51:32]      | -
// m_      | out | smoothed_value[31:0], rate[63:32]   | snapped
// A word runs the sequencer from acceptance until m_tvalid rises; the second division
// is skipped when x >= 32.0. s_tready rises in the cycle after the result is taken.
// Each division holds the sequencer until it is done; each of ten products is
// formed as a low and a high half in one 24x32 multiplier.
// Reset: synchronous aresetn clears value, rate and registers to reset values.
// s_tready is low while a word is in work or its result waits on m_tready.
module critically_damped_smoother_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // target, time_step
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // smoothed_value, rate
    output logic        m_tuser,   // snapped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [4:0] {
        S_IDLE, S_OM, S_OMW, S_X, S_X2, S_X3, S_X4, S_P, S_E, S_EW, S_MC,
        S_CH, S_S, S_T, S_V1, S_R, S_NV, S_FIN, S_OUT
    } state_t;
    state_t state_reg;

    logic [30:0] st_cfg_reg, ms_cfg_reg;
    logic signed [31:0] cv_reg, cr_reg, tgt_reg, out_v_reg, out_r_reg;
    logic [19:0] dt_reg;
    logic [31:0] om_reg, x_reg, x2_reg, x3_reg, e_reg;
    logic [35:0] x4_reg;
    logic [47:0] maxc_reg;
    cds_pkg::wide_t ch_reg, s_reg, tmp_reg, v1_reg, nr_reg, acc_reg;
    logic snap_reg;

    // shared multiplier: sign(a)*trunc(|a|*b>>16), saturated; low half then high half
    cds_pkg::wide_t mul_a;
    logic [31:0] mul_b;
    logic mul_st, mph_reg;
    logic [47:0] mag;
    logic [55:0] mpart, plo_reg;
    logic [79:0] prod;
    logic [47:0] pr;
    cds_pkg::wide_t mul_y;
    always_comb begin
        mag = mul_a[48] ? 48'(-mul_a) : mul_a[47:0];
        mpart = 56'(mph_reg ? mag[47:24] : mag[23:0]) * 56'(mul_b);
        prod = {mpart, 24'd0} + 80'(plo_reg);
        pr = (prod[79:16] > 64'(cds_pkg::WideLim)) ? cds_pkg::WideLim : prod[63:16];
        mul_y = mul_a[48] ? -$signed({1'b0, pr}) : $signed({1'b0, pr});
    end

    logic [30:0] st;
    assign st = (st_cfg_reg < cds_pkg::StFloor) ? cds_pkg::StFloor : st_cfg_reg;

    logic dv_start, dv_done;
    logic [33:0] dv_num, dv_quo;
    logic [33:0] dv_den, p_reg;
    assign dv_num = (state_reg == S_OM) ? 34'h2_0000_0000 : 34'h1_0000_0000;
    assign dv_den = (state_reg == S_OM) ? 34'(st) : p_reg;
    assign dv_start = (state_reg == S_OM) || (state_reg == S_E);
    cds_div u_div (.aclk, .aresetn, .start(dv_start), .num(dv_num), .den(dv_den),
                   .done(dv_done), .quo(dv_quo));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_st = 1'b0;
        unique case (state_reg)
            S_X:  begin mul_a = 49'(om_reg); mul_b = 32'(dt_reg); mul_st = 1'b1; end
            S_X2: begin mul_a = 49'(x_reg); mul_b = x_reg; mul_st = 1'b1; end
            S_X3: begin mul_a = 49'(x2_reg); mul_b = x_reg; mul_st = 1'b1; end
            S_X4: begin mul_a = 49'(x2_reg); mul_b = x2_reg; mul_st = 1'b1; end
            S_MC: begin mul_a = 49'(ms_cfg_reg); mul_b = 32'(st); mul_st = 1'b1; end
            S_S:  begin mul_a = ch_reg; mul_b = om_reg; mul_st = 1'b1; end
            S_T:  begin mul_a = s_reg; mul_b = 32'(dt_reg); mul_st = 1'b1; end
            S_V1: begin mul_a = tmp_reg; mul_b = om_reg; mul_st = 1'b1; end
            S_R:  begin mul_a = v1_reg; mul_b = e_reg; mul_st = 1'b1; end
            S_NV: begin mul_a = acc_reg; mul_b = e_reg; mul_st = 1'b1; end
            default: ;
        endcase
    end

    logic [53:0] psum;
    assign psum = 54'(4502) * 54'(x4_reg) + 54'(9004) * 54'(x3_reg)
                + 54'(33766) * 54'(x2_reg) + 54'(65281) * 54'(x_reg)
                + 54'(65562) * 54'(65536) + 54'(32768);

    cds_pkg::wide_t chg, des, cvw, tgw, nvf;
    always_comb begin
        cvw = 49'(cv_reg);
        tgw = 49'(tgt_reg);
        chg = cvw - tgw;
        if (chg > $signed({1'b0, maxc_reg})) chg = $signed({1'b0, maxc_reg});
        if (chg < -$signed({1'b0, maxc_reg})) chg = -$signed({1'b0, maxc_reg});
        des = cvw - ch_reg;
        nvf = cds_pkg::sat_wide(51'(des) + 51'(mul_y));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_cfg_reg <= cds_pkg::StReset;
            ms_cfg_reg <= cds_pkg::MsReset;
            cv_reg <= '0;
            cr_reg <= '0;
            mph_reg <= 1'b0;
        end else begin
            mph_reg <= mul_st && !mph_reg;
            plo_reg <= mpart;
            if (psel && penable && pwrite) begin
                if (paddr[2] == cds_pkg::RegSmoothTime && paddr[1:0] == 2'b00)
                    st_cfg_reg <= pwdata[30:0];
                else if (paddr[2] == cds_pkg::RegMaxSpeed && paddr[1:0] == 2'b00)
                    ms_cfg_reg <= pwdata[30:0];
            end
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    tgt_reg <= s_tdata[31:0];
                    dt_reg <= s_tdata[51:32];
                    state_reg <= S_OM;
                end
                S_OM: state_reg <= S_OMW;
                S_OMW: if (dv_done) begin
                    om_reg <= dv_quo[31:0];
                    state_reg <= S_X;
                end
                S_X: if (mph_reg) begin
                    // x at or above 32.0 is held at the cap
                    x_reg <= (mul_y[47:0] >= 48'(cds_pkg::XCap)) ? cds_pkg::XCap
                                                                  : mul_y[31:0];
                    state_reg <= S_X2;
                end
                S_X2: if (mph_reg) begin x2_reg <= mul_y[31:0]; state_reg <= S_X3; end
                S_X3: if (mph_reg) begin x3_reg <= mul_y[31:0]; state_reg <= S_X4; end
                S_X4: if (mph_reg) begin x4_reg <= mul_y[35:0]; state_reg <= S_P; end
                S_P: begin
                    p_reg <= psum[49:16];
                    state_reg <= (x_reg >= cds_pkg::XCap) ? S_MC : S_E;
                    e_reg <= '0;
                end
                S_E: state_reg <= S_EW;
                S_EW: if (dv_done) begin
                    e_reg <= dv_quo[31:0];
                    state_reg <= S_MC;
                end
                S_MC: if (mph_reg) begin maxc_reg <= mul_y[47:0]; state_reg <= S_CH; end
                S_CH: begin ch_reg <= chg; state_reg <= S_S; end
                S_S: if (mph_reg) begin
                    s_reg <= cds_pkg::sat_wide(51'(49'(cr_reg)) + 51'(mul_y));
                    state_reg <= S_T;
                end
                S_T: if (mph_reg) begin
                    tmp_reg <= mul_y;
                    acc_reg <= cds_pkg::sat_wide(51'(ch_reg) + 51'(mul_y));
                    state_reg <= S_V1;
                end
                S_V1: if (mph_reg) begin
                    v1_reg <= cds_pkg::sat_wide(51'(49'(cr_reg)) - 51'(mul_y));
                    state_reg <= S_R;
                end
                S_R: if (mph_reg) begin nr_reg <= mul_y; state_reg <= S_NV; end
                S_NV: if (mph_reg) begin
                    snap_reg <= (tgt_reg > cv_reg) == (nvf > tgw);
                    acc_reg <= nvf;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    out_v_reg <= snap_reg ? tgt_reg : cds_pkg::sat32(acc_reg);
                    out_r_reg <= snap_reg ? 32'sd0 : cds_pkg::sat32(nr_reg);
                    cv_reg <= snap_reg ? tgt_reg : cds_pkg::sat32(acc_reg);
                    cr_reg <= snap_reg ? 32'sd0 : cds_pkg::sat32(nr_reg);
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {out_r_reg, out_v_reg};
    assign m_tuser = snap_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cds_pkg::RegMaxSpeed) ? {1'b0, ms_cfg_reg}
                                                       : {1'b0, st_cfg_reg};

`ifndef SYNTHESIS
    a_snap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[63:32] == 32'd0) else $error("snap rate");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("busy overlap");
    a_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> s_tready) else $error("return idle");
`endif
endmodule

@@ src/cds_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies; standalone arithmetic.
`timescale 1ns / 1ps
module cds_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [33:0] num,
    input  logic [33:0] den,
    output logic        done,
    output logic [33:0] quo
);
    logic [33:0] q_reg, q_next;
    logic [33:0] r_reg, r_next;
    logic [33:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [34:0] rs;

    always_comb begin
        rs = {r_reg, q_reg[33]};
        q_next = {q_reg[32:0], 1'b0};
        r_next = rs[33:0];
        if (rs >= {1'b0, d_reg}) begin
            r_next = 34'(rs - {1'b0, d_reg});
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd34;
                q_reg <= num;
                r_reg <= '0;
                d_reg <= den;
            end else if (busy_reg) begin
                q_reg <= q_next;
                r_reg <= r_next;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end
    assign quo = q_reg;
endmodule
